// File: rtl/mac_role_assignment_table_macros.svh
// assertion macros for the mac role assignment table
// used by the top level only; no other dependencies
`ifndef MAC_ROLE_ASSIGNMENT_TABLE_MACROS_SVH
`define MAC_ROLE_ASSIGNMENT_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MRAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MRAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mrat_pkg.sv
// shared types, codes and constants for the mac role assignment table
// no dependencies
package mrat_pkg;

	localparam int MAC_BYTES       = 6;
	localparam int MAC_W           = MAC_BYTES * 8;
	localparam int ROLE_W          = 2;
	localparam int CMD_W           = 3;
	localparam int STATUS_W        = 2;
	localparam int IDX_IN_W        = 3;
	localparam int COUNT_OUT_W     = 4;
	localparam int NUM_ROLES       = 3;
	localparam int TABLE_DEPTH_DEF = 8;

	typedef logic [MAC_W-1:0]       mac_t;
	typedef logic [ROLE_W-1:0]      role_t;
	typedef logic [CMD_W-1:0]       cmd_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [IDX_IN_W-1:0]    idx_in_t;
	typedef logic [COUNT_OUT_W-1:0] count_out_t;
	typedef logic [NUM_ROLES-1:0]   held_t;

	// command codes
	localparam cmd_t CMD_GET    = 3'd0;
	localparam cmd_t CMD_SET    = 3'd1;
	localparam cmd_t CMD_SWAP   = 3'd2;
	localparam cmd_t CMD_FORGET = 3'd3;
	localparam cmd_t CMD_READ   = 3'd4;

	// status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_INVALID   = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;

	// roles
	localparam role_t ROLE_POINTER = 2'd0;
	localparam role_t ROLE_WHEEL   = 2'd1;
	localparam role_t ROLE_MOD     = 2'd2;
	localparam role_t ROLE_INVALID = 2'd3;

	typedef struct packed {
		cmd_t    command;
		mac_t    mac_a;
		mac_t    mac_b;
		role_t   new_role;
		idx_in_t entry_index;
	} request_t;

	typedef struct packed {
		role_t      role_out;
		status_t    status;
		logic       changed;
		count_out_t entry_count_out;
		mac_t       mac_out;
	} result_t;

	// one table entry as held in the store
	typedef struct packed {
		mac_t  key;
		role_t role;
	} entry_t;

	// first role that no entry holds, the modifier role when all are held
	function automatic role_t free_role(input held_t held);
		role_t r;
		if (!held[ROLE_POINTER])
			r = ROLE_POINTER;
		else if (!held[ROLE_WHEEL])
			r = ROLE_WHEEL;
		else
			r = ROLE_MOD;
		return r;
	endfunction

endpackage

// File: rtl/mrat_store.sv
// entry store: one write port, one read port with registered read data
// depends on mrat_pkg for the entry type
module mrat_store #(
	parameter int DEPTH = mrat_pkg::TABLE_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  mrat_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output mrat_pkg::entry_t rdata
);

	mrat_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: rtl/mac_role_assignment_table.sv
// top level of the mac role assignment table: command sequencer and checks
// depends on mrat_pkg, mrat_store and mac_role_assignment_table_macros.svh
`include "mac_role_assignment_table_macros.svh"

// A command item is taken when start is high and busy is low; its single
// result item appears on result for exactly one cycle with done high, and
// the receiver cannot hold it off, so it must be captured on that cycle.
// All work goes through one entry store, with one write and one read port,
// and one 48-bit key comparator under a small sequencer, so the time per item
// follows the number of valid entries n: a scan streams one entry a cycle and
// stops at the first hit. Get and set scan once, swap scans twice, forget
// shifts every entry above the hit down by one, a read entry reads the store
// once, and commands rejected on their arguments finish without a scan.
// busy stays high until the result is out; the next item may be started in
// the same cycle as done. There is no clearing pass after reset: only entries
// below the valid count are ever read.
module mac_role_assignment_table #(
	parameter int TABLE_DEPTH = mrat_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mrat_pkg::request_t request,
	output logic               done,
	output mrat_pkg::result_t  result
);

	// store address width and a count width that can hold the depth itself
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	// width wide enough to compare a requested position with the count
	localparam int PW = (CW > mrat_pkg::IDX_IN_W) ? CW : mrat_pkg::IDX_IN_W;

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_ACT      = 3'd2;
	localparam logic [2:0] S_SWAP2    = 3'd3;
	localparam logic [2:0] S_SHIFT_RD = 3'd4;
	localparam logic [2:0] S_SHIFT_WR = 3'd5;
	localparam logic [2:0] S_READ     = 3'd6;

	logic [2:0]         state_q;
	mrat_pkg::request_t req_q;
	logic [CW-1:0]      count_q;

	// scan walker: idx_q is the next address to read, chk_q the entry
	// whose data sits on the store output when pend_q is set
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      chk_q;
	logic               pend_q;
	logic               pass_q;
	mrat_pkg::held_t    held_q;

	// outcome of the latest scan, and of the first swap pass
	logic               fnd_q;
	logic [AW-1:0]      fidx_q;
	mrat_pkg::role_t    frole_q;
	logic               a_fnd_q;
	logic [AW-1:0]      a_idx_q;
	mrat_pkg::role_t    a_role_q;

	// result registers
	logic               done_q;
	mrat_pkg::role_t    role_q;
	mrat_pkg::status_t  status_q;
	logic               changed_q;
	mrat_pkg::mac_t     mac_q;

	// store port
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	mrat_pkg::entry_t   mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	mrat_pkg::entry_t   mem_rdata;

	logic               accept;
	logic               pos_ok;
	logic               room;
	logic               hit;
	logic               scan_more;
	logic               shift_more;
	logic [CW-1:0]      idx_nxt;
	mrat_pkg::mac_t     cmp_key;
	mrat_pkg::held_t    held_nxt;
	mrat_pkg::role_t    new_entry_role;
	logic               swap_differs;

	mrat_store #(
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	always_comb begin
		result.role_out        = role_q;
		result.status          = status_q;
		result.changed         = changed_q;
		result.entry_count_out = mrat_pkg::count_out_t'(count_q);
		result.mac_out         = mac_q;
	end

	// read position checked against the valid count at the input
	assign pos_ok = PW'(request.entry_index) < PW'(count_q);
	assign room   = count_q < CW'(TABLE_DEPTH);

	// the shared key comparator: first key on the first pass, second key on
	// the second swap pass
	assign cmp_key   = pass_q ? req_q.mac_b : req_q.mac_a;
	assign hit       = pend_q && (mem_rdata.key == cmp_key);
	assign scan_more = idx_q < count_q;

	// roles seen so far, for the free role of a get miss
	assign held_nxt = held_q | {mem_rdata.role == mrat_pkg::ROLE_MOD,
	                            mem_rdata.role == mrat_pkg::ROLE_WHEEL,
	                            mem_rdata.role == mrat_pkg::ROLE_POINTER};

	assign new_entry_role = mrat_pkg::free_role(held_q);
	assign swap_differs   = a_fnd_q && fnd_q && (a_role_q != frole_q);

	// shift-down walker for forget
	assign idx_nxt    = idx_q + CW'(1);
	assign shift_more = idx_nxt < count_q;

	// store control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && request.command == mrat_pkg::CMD_READ && pos_ok) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(request.entry_index);
				end
			end
			S_SCAN: begin
				if (!hit && scan_more) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0];
				end
			end
			S_ACT: begin
				unique case (req_q.command)
					mrat_pkg::CMD_GET: begin
						// append at the end of the table on a miss
						if (!fnd_q && room) begin
							mem_we         = 1'b1;
							mem_waddr      = count_q[AW-1:0];
							mem_wdata.key  = req_q.mac_a;
							mem_wdata.role = new_entry_role;
						end
					end
					mrat_pkg::CMD_SET: begin
						if (fnd_q) begin
							mem_we         = 1'b1;
							mem_waddr      = fidx_q;
							mem_wdata.key  = req_q.mac_a;
							mem_wdata.role = req_q.new_role;
						end
					end
					mrat_pkg::CMD_SWAP: begin
						// first half of the exchange
						if (pass_q && swap_differs) begin
							mem_we         = 1'b1;
							mem_waddr      = a_idx_q;
							mem_wdata.key  = req_q.mac_a;
							mem_wdata.role = frole_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_SWAP2: begin
				mem_we         = 1'b1;
				mem_waddr      = fidx_q;
				mem_wdata.key  = req_q.mac_b;
				mem_wdata.role = a_role_q;
			end
			S_SHIFT_RD: begin
				if (shift_more) begin
					mem_re    = 1'b1;
					mem_raddr = idx_nxt[AW-1:0];
				end
			end
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			S_READ: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			chk_q     <= '0;
			pend_q    <= 1'b0;
			pass_q    <= 1'b0;
			held_q    <= '0;
			fnd_q     <= 1'b0;
			fidx_q    <= '0;
			frole_q   <= '0;
			a_fnd_q   <= 1'b0;
			a_idx_q   <= '0;
			a_role_q  <= '0;
			done_q    <= 1'b0;
			role_q    <= '0;
			status_q  <= mrat_pkg::ST_OK;
			changed_q <= 1'b0;
			mac_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q     <= request;
						role_q    <= '0;
						status_q  <= mrat_pkg::ST_OK;
						changed_q <= 1'b0;
						mac_q     <= '0;
						idx_q     <= '0;
						pend_q    <= 1'b0;
						pass_q    <= 1'b0;
						held_q    <= '0;
						unique case (request.command) inside
							mrat_pkg::CMD_GET,
							mrat_pkg::CMD_FORGET: begin
								state_q <= S_SCAN;
							end
							mrat_pkg::CMD_SET: begin
								// bad role is rejected before any search
								if (request.new_role == mrat_pkg::ROLE_INVALID) begin
									status_q <= mrat_pkg::ST_INVALID;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							mrat_pkg::CMD_SWAP: begin
								if (request.mac_a == request.mac_b) begin
									status_q <= mrat_pkg::ST_INVALID;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							mrat_pkg::CMD_READ: begin
								if (pos_ok) begin
									state_q <= S_READ;
								end else begin
									status_q <= mrat_pkg::ST_INVALID;
									done_q   <= 1'b1;
								end
							end
							default: begin
								status_q <= mrat_pkg::ST_INVALID;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (pend_q)
						held_q <= held_nxt;
					if (hit) begin
						fnd_q   <= 1'b1;
						fidx_q  <= chk_q;
						frole_q <= mem_rdata.role;
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end else if (scan_more) begin
						chk_q  <= idx_q[AW-1:0];
						pend_q <= 1'b1;
						idx_q  <= idx_nxt;
					end else begin
						fnd_q   <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					unique case (req_q.command)
						mrat_pkg::CMD_GET: begin
							if (fnd_q) begin
								role_q <= frole_q;
							end else if (room) begin
								role_q    <= new_entry_role;
								count_q   <= count_q + CW'(1);
								changed_q <= 1'b1;
							end
							// a full table answers with the cursor role
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
						mrat_pkg::CMD_SET: begin
							if (fnd_q)
								changed_q <= 1'b1;
							else
								status_q <= mrat_pkg::ST_NOT_FOUND;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
						mrat_pkg::CMD_SWAP: begin
							if (!pass_q) begin
								// second pass for the other key
								a_fnd_q  <= fnd_q;
								a_idx_q  <= fidx_q;
								a_role_q <= frole_q;
								if (fnd_q) begin
									pass_q  <= 1'b1;
									idx_q   <= '0;
									state_q <= S_SCAN;
								end else begin
									status_q <= mrat_pkg::ST_NOT_FOUND;
									state_q  <= S_IDLE;
									done_q   <= 1'b1;
								end
							end else if (!(a_fnd_q && fnd_q)) begin
								status_q <= mrat_pkg::ST_NOT_FOUND;
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
							end else if (swap_differs) begin
								changed_q <= 1'b1;
								state_q   <= S_SWAP2;
							end else begin
								// equal roles: nothing to exchange
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						mrat_pkg::CMD_FORGET: begin
							if (fnd_q) begin
								idx_q   <= CW'(fidx_q);
								state_q <= S_SHIFT_RD;
							end else begin
								status_q <= mrat_pkg::ST_NOT_FOUND;
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
							end
						end
						default: begin
							status_q <= mrat_pkg::ST_INVALID;
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
						end
					endcase
				end
				S_SWAP2: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SHIFT_RD: begin
					if (shift_more) begin
						state_q <= S_SHIFT_WR;
					end else begin
						count_q   <= count_q - CW'(1);
						changed_q <= 1'b1;
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_nxt;
					state_q <= S_SHIFT_RD;
				end
				S_READ: begin
					role_q  <= mem_rdata.role;
					mac_q   <= mem_rdata.key;
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`MRAT_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result strobe while sequencer busy")
	`MRAT_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH), "count above depth")
	`MRAT_ASSERT_NXT(a_accept_prog, clk, arst_n, accept, busy || done, "accepted item dropped")
	`MRAT_ASSERT_IMP(a_changed_ok, clk, arst_n, done && result.changed, result.status == mrat_pkg::ST_OK, "change reported with error status")

endmodule
